// ===== design/message_text_transcoder_core_assert.svh =====
// Assertion macros used by the checker file mtt_checker.sv
`ifndef MESSAGE_TEXT_TRANSCODER_CORE_ASSERT_SVH
`define MESSAGE_TEXT_TRANSCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Types, codes and the control-code size table of the message text transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

    localparam int POS_WIDTH        = 16;
    localparam int CAP_WIDTH        = 16;
    localparam int REP_WIDTH        = 16;
    localparam int CODE_TABLE_DEPTH = 125;
    localparam int MAX_RESULTS      = 6;
    localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W            = $clog2(MAX_RESULTS);

    localparam logic [7:0] TAG_CODE     = 8'h80;
    localparam logic [7:0] CTL_CODE     = 8'h7F;
    localparam logic [7:0] NEWLINE_CODE = 8'hCD;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] GLYPH_CODE   = 8'hFE;
    localparam logic [7:0] NULL_CODE    = 8'h00;
    localparam logic [7:0] BREAK_B0     = 8'h01;
    localparam logic [7:0] BREAK_B2     = 8'h03;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd2048;

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TAG_LEN,
        MODE_TAG_BODY,
        MODE_CTL_ID,
        MODE_CTL_SKIP
    } mode_t;

    typedef struct packed {
        logic [7:0]           data;
        logic [REP_WIDTH-1:0] rep;
        logic                 last;
        logic                 status;
        logic [15:0]          total;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] item;
        cnt_t                      count;
    } burst_t;

    localparam logic [3:0] CODE_SIZE_ROM [CODE_TABLE_DEPTH] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd5, 4'd2, 4'd2,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd2, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd6, 4'd8, 4'd10, 4'd6, 4'd8,
        4'd10, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd6, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd4, 4'd4,
        4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd6, 4'd3, 4'd3, 4'd4, 4'd3,
        4'd2, 4'd2, 4'd6, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3,
        4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4,
        4'd4, 4'd12, 4'd14, 4'd2, 4'd3
    };

    function automatic result_t make_result(
        input logic [7:0]           data,
        input logic [REP_WIDTH-1:0] rep,
        input logic                 last,
        input logic                 status,
        input logic [15:0]          total
    );
        result_t r;
        r.data   = data;
        r.rep    = rep;
        r.last   = last;
        r.status = status;
        r.total  = total;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mtt_parser.sv =====
// ----------------------------------------------------------------------------
// mtt_parser
// Message parse state and the result burst that one accepted byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [7:0]                     in_byte,
    input  wire logic                           in_last,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mtt_pkg::CAP_WIDTH-1:0]  cfg_wr_data,
    output mtt_pkg::burst_t                     burst
);

    mtt_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     skip_reg, skip_next;
    logic [7:0]     off_reg, off_next;
    logic           match_reg, match_next;
    mtt_pkg::pos_t  pend_reg, pend_next;
    mtt_pkg::pos_t  wp_reg, wp_next;
    logic           glyph_reg, glyph_next;
    logic           stopped_reg, stopped_next;
    logic [mtt_pkg::CAP_WIDTH-1:0] cap_reg;

    logic [mtt_pkg::CAP_WIDTH-1:0] limit;
    logic [mtt_pkg::POS_WIDTH:0]   pos;
    logic [mtt_pkg::POS_WIDTH+1:0] pos3;
    logic          stop_now;
    logic          fit;
    logic [7:0]    tag_rem;
    logic [3:0]    ctl_total;
    logic [3:0]    ctl_params;
    logic [7:0]    skip_dec;
    logic          match_upd;
    logic          is_other;
    logic          do_flush;
    mtt_pkg::cnt_t k;

    assign limit    = (cap_reg >= 16'd3) ? cap_reg - 16'd3 : '0;
    assign pos      = {1'b0, wp_reg} + {1'b0, pend_reg};
    assign pos3     = {1'b0, pos} + (mtt_pkg::POS_WIDTH+2)'(3);
    assign stop_now = stopped_reg || (pos >= limit);
    assign fit      = (pos3 <= limit);
    assign tag_rem  = (in_byte >= 8'd2) ? in_byte - 8'd2 : 8'd0;
    assign ctl_total = (in_byte < 8'(mtt_pkg::CODE_TABLE_DEPTH))
                     ? mtt_pkg::CODE_SIZE_ROM[in_byte[6:0]] : 4'd2;
    assign ctl_params = ctl_total - 4'd2;
    assign skip_dec   = skip_reg - 8'd1;
    assign match_upd  = match_reg
                      && !(off_reg == 8'd0 && in_byte != mtt_pkg::BREAK_B0)
                      && !(off_reg == 8'd2 && in_byte != mtt_pkg::BREAK_B2);
    assign is_other = (in_byte != mtt_pkg::TAG_CODE) && (in_byte != mtt_pkg::CTL_CODE)
                   && (in_byte != mtt_pkg::NEWLINE_CODE) && (in_byte != mtt_pkg::SPACE_CODE);
    assign do_flush = (pend_reg != '0)
                   && ((in_byte == mtt_pkg::SPACE_CODE) || (is_other && fit));

    always_comb
    begin
        mode_next = mode_reg;
        if (!stop_now)
        begin
            unique case (mode_reg)
                mtt_pkg::MODE_TAG_LEN:
                    mode_next = (tag_rem == 8'd0) ? mtt_pkg::MODE_IDLE
                                                  : mtt_pkg::MODE_TAG_BODY;
                mtt_pkg::MODE_TAG_BODY:
                    mode_next = (skip_dec == 8'd0) ? mtt_pkg::MODE_IDLE
                                                   : mtt_pkg::MODE_TAG_BODY;
                mtt_pkg::MODE_CTL_ID:
                    mode_next = (ctl_params == 4'd0) ? mtt_pkg::MODE_IDLE
                                                     : mtt_pkg::MODE_CTL_SKIP;
                mtt_pkg::MODE_CTL_SKIP:
                    mode_next = (skip_dec == 8'd0) ? mtt_pkg::MODE_IDLE
                                                   : mtt_pkg::MODE_CTL_SKIP;
                default:
                    if (in_byte == mtt_pkg::TAG_CODE)
                        mode_next = mtt_pkg::MODE_TAG_LEN;
                    else if (in_byte == mtt_pkg::CTL_CODE)
                        mode_next = mtt_pkg::MODE_CTL_ID;
                    else
                        mode_next = mtt_pkg::MODE_IDLE;
            endcase
        end
        if (in_last)
            mode_next = mtt_pkg::MODE_IDLE;
    end

    always_comb
    begin
        skip_next    = skip_reg;
        off_next     = off_reg;
        match_next   = match_reg;
        pend_next    = pend_reg;
        wp_next      = wp_reg;
        glyph_next   = glyph_reg;
        stopped_next = stop_now;
        burst        = '0;
        k            = '0;
        if (!stop_now)
        begin
            unique case (mode_reg)
                mtt_pkg::MODE_TAG_LEN:
                    if (tag_rem != 8'd0)
                    begin
                        skip_next  = tag_rem;
                        off_next   = 8'd0;
                        match_next = (tag_rem >= 8'd3);
                    end
                mtt_pkg::MODE_TAG_BODY:
                begin
                    match_next = match_upd;
                    off_next   = off_reg + 8'd1;
                    skip_next  = skip_dec;
                    if (skip_dec == 8'd0 && match_upd)
                        pend_next = '0;
                end
                mtt_pkg::MODE_CTL_ID:
                    if (ctl_params != 4'd0)
                        skip_next = 8'(ctl_params);
                mtt_pkg::MODE_CTL_SKIP:
                    skip_next = skip_dec;
                default:
                begin
                    if (do_flush)
                    begin
                        burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                            mtt_pkg::NEWLINE_CODE, 16'(pend_reg), 1'b0, 1'b0, 16'd0);
                        k         = k + 1'b1;
                        pend_next = '0;
                    end
                    if (in_byte == mtt_pkg::NEWLINE_CODE)
                        pend_next = pend_reg + 1'b1;
                    else if (in_byte == mtt_pkg::SPACE_CODE)
                    begin
                        burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                            mtt_pkg::SPACE_CODE, 16'd1, 1'b0, 1'b0, 16'd0);
                        k       = k + 1'b1;
                        wp_next = mtt_pkg::pos_t'(pos + 1);
                    end
                    else if (is_other && fit)
                    begin
                        burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                            mtt_pkg::GLYPH_CODE, 16'd1, 1'b0, 1'b0, 16'd0);
                        k = k + 1'b1;
                        burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                            mtt_pkg::NULL_CODE, 16'd1, 1'b0, 1'b0, 16'd0);
                        k = k + 1'b1;
                        burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                            in_byte, 16'd1, 1'b0, 1'b0, 16'd0);
                        k          = k + 1'b1;
                        wp_next    = mtt_pkg::pos_t'(pos + 3);
                        glyph_next = 1'b1;
                    end
                end
            endcase
        end
        if (in_last)
        begin
            if (!glyph_next)
            begin
                burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                    mtt_pkg::NULL_CODE, 16'd0, 1'b1, 1'b1, 16'd0);
                k = k + 1'b1;
            end
            else
            begin
                burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                    mtt_pkg::CTL_CODE, 16'd1, 1'b0, 1'b0, 16'd0);
                k = k + 1'b1;
                burst.item[k[mtt_pkg::IDX_W-1:0]] = mtt_pkg::make_result(
                    mtt_pkg::NULL_CODE, 16'd1, 1'b1, 1'b0, 16'(wp_next) + 16'd2);
                k = k + 1'b1;
            end
            skip_next    = 8'd0;
            off_next     = 8'd0;
            match_next   = 1'b0;
            pend_next    = '0;
            wp_next      = '0;
            glyph_next   = 1'b0;
            stopped_next = 1'b0;
        end
        burst.count = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mtt_pkg::MODE_IDLE;
            skip_reg    <= 8'd0;
            off_reg     <= 8'd0;
            match_reg   <= 1'b0;
            pend_reg    <= '0;
            wp_reg      <= '0;
            glyph_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            skip_reg    <= skip_next;
            off_reg     <= off_next;
            match_reg   <= match_next;
            pend_reg    <= pend_next;
            wp_reg      <= wp_next;
            glyph_reg   <= glyph_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= mtt_pkg::CAP_RESET;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

endmodule

`default_nettype wire

// ===== design/mtt_emitter.sv =====
// ----------------------------------------------------------------------------
// mtt_emitter
// Result register: holds one burst, sends one request per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_emitter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire mtt_pkg::burst_t  burst,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic                  free,
    output mtt_pkg::result_t      head
);

    mtt_pkg::result_t [mtt_pkg::MAX_RESULTS-1:0] item_reg;
    mtt_pkg::cnt_t                               count_reg;
    logic                                        out_acc;

    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && !out_stall;
    assign free      = (count_reg == '0) || (count_reg == mtt_pkg::cnt_t'(1) && out_acc);
    assign head      = item_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (load)
            count_reg <= burst.count;
        else if (out_acc)
            count_reg <= count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= burst.item;
        else if (out_acc)
        begin
            for (int i = 0; i < mtt_pkg::MAX_RESULTS - 1; i++)
                item_reg[i] <= item_reg[i+1];
        end
    end

endmodule

`default_nettype wire

// ===== design/message_text_transcoder_core.sv =====
// Results of an accepted byte appear from the next cycle, one per cycle unless stalled.
// A glyph byte yields three results and a final byte up to six; a new byte is taken
// only once the output holds no result or its last result is being taken.
// Bytes with no results (newlines, tag and control bytes) do not hold off the next byte.
// Reset clears all message state and restores the capacity register cap_reg to 2048.
// ----------------------------------------------------------------------------
// message_text_transcoder_core
// Rewrites message bytes into the internal text encoding, one byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

module message_text_transcoder_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic [mtt_pkg::REP_WIDTH-1:0]      repeat_res,
    output logic                               out_last,
    output logic                               status,
    output logic [15:0]                        total_size,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mtt_pkg::CAP_WIDTH-1:0] cfg_wr_data
);

    mtt_pkg::burst_t  burst;
    mtt_pkg::result_t head;
    logic             free;
    logic             accept;

    assign in_stall = !free;
    assign accept   = in_valid && free;

    mtt_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .burst       (burst)
    );

    mtt_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .burst     (burst),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (free),
        .head      (head)
    );

    assign out_byte   = head.data;
    assign repeat_res = head.rep;
    assign out_last   = head.last;
    assign status     = head.status;
    assign total_size = head.total;

endmodule

`default_nettype wire

// ===== design/mtt_checker.sv =====
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the transcoder core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_text_transcoder_core_assert.svh"

module mtt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  out_byte,
    input  wire logic [15:0] repeat_res,
    input  wire logic        out_last,
    input  wire logic        status,
    input  wire logic [15:0] total_size
);

    `MTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out request dropped")
    `MTT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({out_byte, out_last}), "out payload changed")
    `MTT_ASSERT_NOW(a_status_final, out_valid && status, out_last && repeat_res == 16'd0 && total_size == 16'd0, "status on non-final")
    `MTT_ASSERT_NOW(a_mid_clean, out_valid && !out_last, !status && total_size == 16'd0 && repeat_res != 16'd0, "bad mid-message result")

endmodule

bind message_text_transcoder_core mtt_checker u_mtt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .repeat_res  (repeat_res),
    .out_last    (out_last),
    .status      (status),
    .total_size  (total_size)
);

`default_nettype wire
